>>> src/shbh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shbh_pkg
// types, command codes, round constants and helper functions for the hasher
// ----------------------------------------------------------------------------
package shbh_pkg;

  typedef enum logic [1:0] {
    MODE_ABSORB  = 2'd0,
    MODE_FINISH  = 2'd1,
    MODE_PEEK    = 2'd2,
    MODE_RESTART = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] data;
  } cmd_t;

  localparam logic [7:0] PAD_MARKER = 8'h80;
  localparam logic [6:0] LEN_POS    = 7'd56;

  function automatic logic [31:0] ror(input logic [31:0] v, input int n);
    ror = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    case (i)
      3'd0:    init_h = 32'h6a09e667;
      3'd1:    init_h = 32'hbb67ae85;
      3'd2:    init_h = 32'h3c6ef372;
      3'd3:    init_h = 32'ha54ff53a;
      3'd4:    init_h = 32'h510e527f;
      3'd5:    init_h = 32'h9b05688c;
      3'd6:    init_h = 32'h1f83d9ab;
      default: init_h = 32'h5be0cd19;
    endcase
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    round_k = k[i];
  endfunction

endpackage

>>> src/shbh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shbh_front
// accepts input items, decodes the command and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module shbh_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic [1:0]          in_tuser,
  output logic                cmd_valid,
  output shbh_pkg::cmd_t      cmd,
  input  logic                cmd_pop
);
  import shbh_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r].mode <= mode_t'(in_tuser);
      q_r[wp_r].data <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> src/shbh_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shbh_core
// block buffer, padding, one-round-per-cycle compression and digest output
// ----------------------------------------------------------------------------
module shbh_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  shbh_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_digest,
  output logic [2:0]          out_index,
  output logic                out_last
);
  import shbh_pkg::*;

  state_t      state_r, state_nxt;
  logic [7:0]  mem [64];
  logic [7:0]  rd_r;
  logic [31:0] chain_r [8];
  logic [31:0] hw_r [8];
  logic [31:0] hsum [8];
  logic [31:0] w_r [16];
  logic [31:0] va_r, vb_r, vc_r, vd_r, ve_r, vf_r, vg_r, vh_r;
  logic [23:0] wacc_r;
  logic [5:0]  fill_r;
  logic [63:0] msg_r;
  logic [6:0]  cnt_r;
  logic [5:0]  pos_r;
  logic        ldv_r;
  logic [2:0]  idx_r;
  mode_t       mode_r;
  logic        has_data_r, marker_r, final_r;
  logic [6:0]  lim_r;
  logic [7:0]  ld_byte;
  logic [63:0] bits;
  logic [31:0] t1, t2, s0, s1, w_new;
  logic        accept;

  assign accept = cmd_valid && (state_r == ST_IDLE);
  assign bits   = {msg_r[60:0], 3'b000};

  // padded byte stream of the block being loaded
  always_comb begin
    if (has_data_r && ({1'b0, pos_r} < lim_r))
      ld_byte = rd_r;
    else if (marker_r && ({1'b0, pos_r} == lim_r))
      ld_byte = PAD_MARKER;
    else if (final_r && ({1'b0, pos_r} >= LEN_POS))
      ld_byte = 8'(bits >> {~pos_r[2:0], 3'b000});
    else
      ld_byte = 8'h00;
  end

  always_comb begin
    t1 = vh_r + (ror(ve_r, 6) ^ ror(ve_r, 11) ^ ror(ve_r, 25)) +
         ((ve_r & vf_r) ^ (~ve_r & vg_r)) + round_k(cnt_r[5:0]) + w_r[0];
    t2 = (ror(va_r, 2) ^ ror(va_r, 13) ^ ror(va_r, 22)) +
         ((va_r & vb_r) ^ (va_r & vc_r) ^ (vb_r & vc_r));
    s0 = ror(w_r[1], 7) ^ ror(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = ror(w_r[14], 17) ^ ror(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = w_r[0] + s0 + w_r[9] + s1;
    hsum[0] = hw_r[0] + va_r;
    hsum[1] = hw_r[1] + vb_r;
    hsum[2] = hw_r[2] + vc_r;
    hsum[3] = hw_r[3] + vd_r;
    hsum[4] = hw_r[4] + ve_r;
    hsum[5] = hw_r[5] + vf_r;
    hsum[6] = hw_r[6] + vg_r;
    hsum[7] = hw_r[7] + vh_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.mode)
            MODE_ABSORB:  if (fill_r == 6'd63) state_nxt = ST_LOAD;
            MODE_FINISH:  state_nxt = ST_LOAD;
            MODE_PEEK:    state_nxt = ST_LOAD;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOAD:  if (ldv_r && pos_r == 6'd63) state_nxt = ST_ROUND;
      ST_ROUND: if (cnt_r[5:0] == 6'd63) state_nxt = ST_ADD;
      ST_ADD: begin
        if (mode_r == MODE_ABSORB) state_nxt = ST_IDLE;
        else if (!final_r)         state_nxt = ST_LOAD;
        else                       state_nxt = ST_EMIT;
      end
      ST_EMIT:  if (out_ready && idx_r == 3'd7) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop    = (state_r == ST_IDLE);
    out_valid  = (state_r == ST_EMIT);
    out_digest = hw_r[idx_r];
    out_index  = idx_r;
    out_last   = (idx_r == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (accept && cmd.mode == MODE_ABSORB) mem[fill_r] <= cmd.data;
    rd_r <= mem[cnt_r[5:0]];
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        mode_r <= cmd.mode;
        for (int i = 0; i < 8; i++) hw_r[i] <= chain_r[i];
        has_data_r <= 1'b1;
        marker_r   <= (cmd.mode != MODE_ABSORB);
        final_r    <= (cmd.mode != MODE_ABSORB) && (fill_r < 6'd56);
        lim_r      <= (cmd.mode == MODE_ABSORB) ? 7'd64 : {1'b0, fill_r};
      end
      ST_LOAD: begin
        pos_r <= cnt_r[5:0];
        if (ldv_r) begin
          wacc_r <= {wacc_r[15:0], ld_byte};
          if (pos_r[1:0] == 2'd3) begin
            for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
            w_r[15] <= {wacc_r, ld_byte};
          end
          if (pos_r == 6'd63) begin
            va_r <= hw_r[0]; vb_r <= hw_r[1]; vc_r <= hw_r[2]; vd_r <= hw_r[3];
            ve_r <= hw_r[4]; vf_r <= hw_r[5]; vg_r <= hw_r[6]; vh_r <= hw_r[7];
          end
        end
      end
      ST_ROUND: begin
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
        w_r[15] <= w_new;
        vh_r <= vg_r; vg_r <= vf_r; vf_r <= ve_r; ve_r <= vd_r + t1;
        vd_r <= vc_r; vc_r <= vb_r; vb_r <= va_r; va_r <= t1 + t2;
      end
      ST_ADD: begin
        for (int i = 0; i < 8; i++) hw_r[i] <= hsum[i];
        // overflow block of a pad: length only
        has_data_r <= 1'b0;
        marker_r   <= 1'b0;
        final_r    <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int i = 0; i < 8; i++) chain_r[i] <= init_h(3'(i));
      fill_r  <= 6'd0;
      msg_r   <= 64'd0;
      cnt_r   <= 7'd0;
      ldv_r   <= 1'b0;
      idx_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      ldv_r   <= (state_r == ST_LOAD) && !cnt_r[6];
      case (state_r)
        ST_IDLE: begin
          cnt_r <= 7'd0;
          if (cmd_valid) begin
            case (cmd.mode)
              MODE_ABSORB: begin
                fill_r <= fill_r + 6'd1;
                msg_r  <= msg_r + 64'd1;
              end
              MODE_RESTART: begin
                for (int i = 0; i < 8; i++) chain_r[i] <= init_h(3'(i));
                fill_r <= 6'd0;
                msg_r  <= 64'd0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_LOAD: begin
          if (ldv_r && pos_r == 6'd63) cnt_r <= 7'd0;
          else if (!cnt_r[6])          cnt_r <= cnt_r + 7'd1;
        end
        ST_ROUND: begin
          if (cnt_r[5:0] == 6'd63) cnt_r <= 7'd0;
          else                     cnt_r <= cnt_r + 7'd1;
        end
        ST_ADD: begin
          cnt_r <= 7'd0;
          idx_r <= 3'd0;
          if (mode_r == MODE_ABSORB)
            for (int i = 0; i < 8; i++) chain_r[i] <= hsum[i];
        end
        ST_EMIT: begin
          if (out_ready) begin
            idx_r <= idx_r + 3'd1;
            // a finished message leaves the block as after reset
            if (idx_r == 3'd7 && mode_r == MODE_FINISH) begin
              for (int i = 0; i < 8; i++) chain_r[i] <= init_h(3'(i));
              fill_r <= 6'd0;
              msg_r  <= 64'd0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> src/sha256_byte_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// sha-256 over a byte stream: absorb, finish, peek and restart commands
// ----------------------------------------------------------------------------
// absorb item: taken from the queue while idle; the 64th byte of a block starts its compression
// (byte loading from the block ram, 64 rounds, then the add of the chaining values)
// finish / peek: accept, then loading, rounds and add for each padded block (one or two),
// then 8 result items at one per cycle while out_tready is high
// rate is set by the single shared round unit and the one-byte ram read port
// reset (rst_n low, synchronous): initial hash values, empty message, queue empty
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        out_tlast   // last_word
);
  import shbh_pkg::*;

  cmd_t        cmd;
  logic        cmd_valid, cmd_pop;
  logic [31:0] digest;
  logic [2:0]  word_idx;

  // front: item queue and command decode
  shbh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // back: buffering, padding, compression and digest words
  shbh_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_digest (digest),
    .out_index  (word_idx),
    .out_last   (out_tlast)
  );

  assign out_tdata = {5'b00000, word_idx, digest};

endmodule

>>> tb/sv/tb_sha256_byte_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha256_byte_stream_hasher
// streams absorb, finish, peek and restart items through the hasher, predicts
// each digest with its own sha-256 model and checks every result item in order
// ----------------------------------------------------------------------------
module tb_sha256_byte_stream_hasher;
  import shbh_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;

  sha256_byte_stream_hasher dut (.*);

  // stimulus queue and expected digest words
  cmd_t         cmd_q[$];
  digest_item_t digest_q[$];

  // predictor state
  logic [31:0] hash_state[8];
  logic [7:0]  blk_bytes[64];
  int          blk_fill;
  logic [63:0] msg_len;
  bit          msg_closed;

  int errors;
  int words_seen;
  int finishes;
  int peeks;
  int blocks;

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  recv_hold;
  bit  send_pause;

  localparam logic [31:0] K_TAB[64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] IV_TAB[8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] rotr(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  // one 64-round compression of a block into h
  function automatic void compress(ref logic [31:0] h[8], input logic [7:0] b[64]);
    logic [31:0] w[64];
    logic [31:0] a, bb, c, d, e, f, g, hh, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {b[4*i], b[4*i+1], b[4*i+2], b[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    a = h[0]; bb = h[1]; c = h[2]; d = h[3];
    e = h[4]; f = h[5]; g = h[6]; hh = h[7];
    for (int i = 0; i < 64; i++) begin
      t1 = hh + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + K_TAB[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & bb) ^ (a & c) ^ (bb & c));
      hh = g; g = f; f = e; e = d + t1;
      d = c; c = bb; bb = a; a = t1 + t2;
    end
    h[0] += a; h[1] += bb; h[2] += c; h[3] += d;
    h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
  endfunction

  function automatic void hasher_clear();
    for (int i = 0; i < 8; i++) hash_state[i] = IV_TAB[i];
    for (int i = 0; i < 64; i++) blk_bytes[i] = '0;
    blk_fill   = 0;
    msg_len    = '0;
    msg_closed = 0;
  endfunction

  // pads a copy of the open message and queues its eight digest words
  function automatic void emit_padded(bit close_msg);
    logic [31:0] h[8];
    logic [7:0]  b[64];
    logic [63:0] bits;
    int          n;
    h = hash_state;
    b = blk_bytes;
    bits = msg_len << 3;
    n = blk_fill;
    b[n] = PAD_MARKER;
    n++;
    if (n > LEN_POS) begin
      while (n < 64) begin b[n] = '0; n++; end
      compress(h, b);
      n = 0;
    end
    while (n < LEN_POS) begin b[n] = '0; n++; end
    for (int i = 0; i < 8; i++) b[56+i] = bits[8*(7-i) +: 8];
    compress(h, b);
    for (int k = 0; k < 8; k++) digest_q.push_back('{h[k], 3'(k), k == 7});
    if (close_msg) begin
      hash_state = h;
      blk_fill   = 0;
      msg_closed = 1;
    end
  endfunction

  function automatic void predict(cmd_t c);
    if (msg_closed) hasher_clear();
    case (c.mode)
      MODE_ABSORB: begin
        blk_bytes[blk_fill] = c.data;
        blk_fill++;
        msg_len++;
        if (blk_fill == 64) begin
          compress(hash_state, blk_bytes);
          blk_fill = 0;
          blocks++;
        end
      end
      MODE_FINISH: begin emit_padded(1); finishes++; end
      MODE_PEEK: begin emit_padded(0); peeks++; end
      default: hasher_clear();
    endcase
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // driver: next pending item is offered once the previous one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
    end else begin
      if (in_tvalid && in_tready) predict('{mode_t'(in_tuser), in_tdata});
      if (!in_tvalid || in_tready) begin
        if (cmd_q.size() > 0 && !send_pause && $urandom_range(99) >= send_idle_pct) begin
          cmd_t c;
          c = cmd_q.pop_front();
          in_tvalid <= 1;
          in_tuser  <= c.mode;
          in_tdata  <= c.data;
        end else begin
          in_tvalid <= 0;
        end
      end
    end
  end

  // monitor: compares each result item with the oldest expected digest word
  always @(posedge clk) begin
    if (rst_n) begin
      out_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
      if (out_tvalid && out_tready) begin
        digest_item_t exp_item;
        digest_item_t got;
        got = '{out_tdata[31:0], out_tdata[34:32], out_tlast};
        words_seen++;
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected result item, actual %h", $time, got);
          errors++;
        end else begin
          exp_item = digest_q.pop_front();
          if (got.word !== exp_item.word || got.idx !== exp_item.idx
              || got.last !== exp_item.last || out_tdata[39:35] !== '0) begin
            $display("%0t: mismatch, expected word %h idx %0d last %0d, actual %h %0d %0d",
                     $time, exp_item.word, exp_item.idx, exp_item.last,
                     got.word, got.idx, got.last);
            errors++;
          end
        end
      end
    end else begin
      out_tready <= 0;
    end
  end

  task automatic push_cmd(mode_t m, logic [7:0] d);
    cmd_q.push_back('{m, d});
  endtask

  task automatic push_message(int len, mode_t ending);
    for (int i = 0; i < len; i++) push_cmd(MODE_ABSORB, 8'($urandom_range(255)));
    push_cmd(ending, 8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    while (cmd_q.size() > 0 || in_tvalid || digest_q.size() > 0) @(posedge clk);
  endtask

  // random part: mostly whole messages with a peek now and then
  task automatic random_phase(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(60, 130) : $urandom_range(0, 20);
      for (int i = 0; i < len; i++) begin
        push_cmd(MODE_ABSORB, 8'($urandom_range(255)));
        if ($urandom_range(15) == 0) begin
          push_cmd(MODE_PEEK, 8'($urandom_range(255)));
          sent++;
        end
      end
      case ($urandom_range(9))
        0: push_cmd(MODE_RESTART, 8'($urandom_range(255)));
        1: push_cmd(MODE_PEEK, 8'($urandom_range(255)));
        default: push_cmd(MODE_FINISH, 8'($urandom_range(255)));
      endcase
      sent += len + 1;
    end
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0; in_tdata = '0; in_tuser = '0; out_tready = 0;
    recv_hold = 0; send_pause = 0; send_idle_pct = 0; recv_idle_pct = 0;
    errors = 0; words_seen = 0; finishes = 0; peeks = 0; blocks = 0;
    hasher_clear();
    repeat (5) @(posedge clk);
    rst_n <= 1;

    // directed: empty message, double finish, peek after finish, extremes of data
    push_cmd(MODE_FINISH, 8'hff);
    push_cmd(MODE_FINISH, 8'h00);
    push_cmd(MODE_PEEK, 8'h5a);
    push_cmd(MODE_ABSORB, 8'h00);
    push_cmd(MODE_ABSORB, 8'hff);
    push_cmd(MODE_PEEK, 8'ha5);
    push_cmd(MODE_ABSORB, 8'h61);
    push_cmd(MODE_RESTART, 8'hff);
    push_cmd(MODE_ABSORB, 8'h61);
    push_cmd(MODE_ABSORB, 8'h62);
    push_cmd(MODE_ABSORB, 8'h63);
    push_cmd(MODE_FINISH, 8'h00);
    wait_drained();
    // 56 bytes: padding spills into a second block
    push_message(56, MODE_PEEK);
    push_cmd(MODE_FINISH, 8'h00);
    wait_drained();

    send_idle_pct = 15; recv_idle_pct = 64;
    random_phase(70);
    wait_drained();

    // long receiver stall while peeks pile up behind it
    recv_hold = 1;
    for (int i = 0; i < 6; i++) push_message(2, MODE_PEEK);
    repeat (400) @(posedge clk);
    recv_hold = 0;
    wait_drained();

    send_idle_pct = 64; recv_idle_pct = 15;
    random_phase(60);
    wait_drained();

    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(60);
    wait_drained();
    repeat (300) @(posedge clk);

    $display("covered %0d finishes, %0d peeks, %0d full blocks, %0d digest words",
             finishes, peeks, blocks, words_seen);
    if (errors == 0 && digest_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule
